// ===== rtl/ecpm_pkg.sv =====
// Field constants, field arithmetic helpers and the point-add microprogram.
package ecpm_pkg;

    localparam int FE_W = 112;
    localparam int MCW  = 7;
    localparam int PCW  = 6;

    localparam logic [FE_W-1:0] P_MOD = 112'hDB7C2ABF62E35E668076BEAD208B;
    localparam logic [FE_W-1:0] C_A   = 112'hDB7C2ABF62E35E668076BEAD2088;
    localparam logic [FE_W-1:0] C_B   = 112'h659EF8BA043916EEDE8911702B22;

    typedef logic [FE_W-1:0] fe_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_STEP, ST_ADD, ST_EXEC, ST_MUL, ST_INV, ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_INV, OP_JMP, OP_END
    } op_t;

    typedef enum logic [3:0] {
        R_X1, R_Y1, R_X2, R_Y2, R_T0, R_T1, R_T2, R_T3, R_T4, R_CA, R_CB, R_ZERO
    } rsel_t;

    typedef struct packed {
        op_t   op;
        rsel_t dst;
        rsel_t a;
        rsel_t b;
    } uop_t;

    localparam logic [PCW-1:0] DBL_PC = 6'd0;
    localparam logic [PCW-1:0] CHD_PC = 6'd15;
    localparam logic [PCW-1:0] COM_PC = 6'd23;

    function automatic fe_t addm(fe_t a, fe_t b);
        logic [FE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, P_MOD}) begin
            s = s - {1'b0, P_MOD};
        end
        return s[FE_W-1:0];
    endfunction

    function automatic fe_t subm(fe_t a, fe_t b);
        logic [FE_W:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + {1'b0, P_MOD} - {1'b0, b};
        end
        return s[FE_W-1:0];
    endfunction

    function automatic fe_t halfm(fe_t a);
        logic [FE_W:0] t;
        t = a[0] ? ({1'b0, a} + {1'b0, P_MOD}) : {1'b0, a};
        return t[FE_W:1];
    endfunction

    function automatic fe_t reducem(fe_t a);
        return (a >= P_MOD) ? (a - P_MOD) : a;
    endfunction

    // Doubling computes slope and intercept from the tangent, chord from the
    // two points; both finish in the common tail that forms x3 and y3.
    function automatic uop_t uop(logic [PCW-1:0] pc);
        uop_t u;
        unique case (pc)
            6'd0:  u = '{OP_ADD, R_T0, R_Y1, R_Y1};
            6'd1:  u = '{OP_INV, R_T0, R_T0, R_T0};
            6'd2:  u = '{OP_MUL, R_T1, R_X1, R_X1};
            6'd3:  u = '{OP_ADD, R_T2, R_T1, R_T1};
            6'd4:  u = '{OP_ADD, R_T2, R_T2, R_T1};
            6'd5:  u = '{OP_ADD, R_T2, R_T2, R_CA};
            6'd6:  u = '{OP_MUL, R_T2, R_T2, R_T0};
            6'd7:  u = '{OP_MUL, R_T3, R_T1, R_X1};
            6'd8:  u = '{OP_SUB, R_T3, R_ZERO, R_T3};
            6'd9:  u = '{OP_MUL, R_T1, R_CA, R_X1};
            6'd10: u = '{OP_ADD, R_T3, R_T3, R_T1};
            6'd11: u = '{OP_ADD, R_T1, R_CB, R_CB};
            6'd12: u = '{OP_ADD, R_T3, R_T3, R_T1};
            6'd13: u = '{OP_MUL, R_T3, R_T3, R_T0};
            6'd14: u = '{OP_JMP, R_T0, R_T0, R_T0};
            6'd15: u = '{OP_SUB, R_T0, R_X2, R_X1};
            6'd16: u = '{OP_INV, R_T0, R_T0, R_T0};
            6'd17: u = '{OP_SUB, R_T2, R_Y2, R_Y1};
            6'd18: u = '{OP_MUL, R_T2, R_T2, R_T0};
            6'd19: u = '{OP_MUL, R_T3, R_Y1, R_X2};
            6'd20: u = '{OP_MUL, R_T1, R_Y2, R_X1};
            6'd21: u = '{OP_SUB, R_T3, R_T3, R_T1};
            6'd22: u = '{OP_MUL, R_T3, R_T3, R_T0};
            6'd23: u = '{OP_MUL, R_T1, R_T2, R_T2};
            6'd24: u = '{OP_SUB, R_T0, R_T1, R_X1};
            6'd25: u = '{OP_SUB, R_T0, R_T0, R_X2};
            6'd26: u = '{OP_MUL, R_T1, R_T1, R_T2};
            6'd27: u = '{OP_SUB, R_T1, R_ZERO, R_T1};
            6'd28: u = '{OP_ADD, R_T4, R_X1, R_X2};
            6'd29: u = '{OP_MUL, R_T4, R_T2, R_T4};
            6'd30: u = '{OP_ADD, R_T1, R_T1, R_T4};
            6'd31: u = '{OP_SUB, R_Y1, R_T1, R_T3};
            6'd32: u = '{OP_ADD, R_X1, R_T0, R_ZERO};
            default: u = '{OP_END, R_T0, R_T0, R_T0};
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/ec_point_add_and_scalar_mult_core.sv =====
// Affine point add and double-and-add scalar multiply on secp112r1.
//
//  channel | dir | tdata (low bit up)                                 | tuser
//  s_      | in  | px_lo px_hi py_lo py_hi qx_lo qx_hi qy_lo qy_hi k_lo k_hi | cmd
//  m_      | out | rx_lo rx_hi ry_lo ry_hi                            | at_infinity
//
// One item at a time; s_tready is high only while idle.
// Each field multiply is bit-serial; each inversion is binary
// extended Euclid, one shift or subtract per cycle.
// A point add is roughly 8 multiplies and one inversion;
// a scalar multiply runs up to 2*SCALAR_BITS adds.
// aresetn clears the controller; the result waits in place until taken.
module ec_point_add_and_scalar_mult_core
    import ecpm_pkg::*;
#(
    parameter int SCALAR_BITS = 112
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [559:0] s_tdata,   // px_lo, px_hi, py_lo, py_hi, qx_lo, qx_hi, qy_lo, qy_hi, k_lo, k_hi
    input  logic [0:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [223:0] m_tdata,   // rx_lo, rx_hi, ry_lo, ry_hi
    output logic [0:0]   m_tuser    // at_infinity
);

    localparam int CW = $clog2(SCALAR_BITS + 1);

    state_t state_reg, state_next;

    fe_t x1_reg, y1_reg, x2_reg, y2_reg, px_reg, py_reg;
    fe_t t0_reg, t1_reg, t2_reg, t3_reg, t4_reg;
    logic inf1_reg, inf2_reg, pinf_reg, mode_reg, half_reg;
    logic [SCALAR_BITS-1:0] k_reg;
    logic [CW-1:0] cnt_reg;
    logic [PCW-1:0] pc_reg;
    fe_t ma_reg, mb_reg, macc_reg;
    logic [MCW-1:0] mcnt_reg;
    fe_t u_reg, v_reg, ix1_reg, ix2_reg;

    uop_t cur;
    fe_t opa, opb, alu_res, mul_step, wr_data, in_px, in_py, in_qx, in_qy;
    logic wr_en, inv_done, add_trivial, mul_last;
    state_t done_st;

    assign cur = uop(pc_reg);

    function automatic fe_t rsel(rsel_t s, fe_t x1, fe_t y1, fe_t x2, fe_t y2,
                                 fe_t a0, fe_t a1, fe_t a2, fe_t a3, fe_t a4);
        fe_t r;
        case (s)
            R_X1:    r = x1;
            R_Y1:    r = y1;
            R_X2:    r = x2;
            R_Y2:    r = y2;
            R_T0:    r = a0;
            R_T1:    r = a1;
            R_T2:    r = a2;
            R_T3:    r = a3;
            R_T4:    r = a4;
            R_CA:    r = C_A;
            R_CB:    r = C_B;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign opa = rsel(cur.a, x1_reg, y1_reg, x2_reg, y2_reg,
                      t0_reg, t1_reg, t2_reg, t3_reg, t4_reg);
    assign opb = rsel(cur.b, x1_reg, y1_reg, x2_reg, y2_reg,
                      t0_reg, t1_reg, t2_reg, t3_reg, t4_reg);

    assign alu_res  = (cur.op == OP_SUB) ? subm(opa, opb) : addm(opa, opb);
    assign mul_step = mb_reg[FE_W-1] ? addm(addm(macc_reg, macc_reg), ma_reg)
                                     : addm(macc_reg, macc_reg);
    assign mul_last = (mcnt_reg == MCW'(1));
    assign inv_done = (u_reg == '0) || (v_reg == '0) ||
                      (u_reg == fe_t'(1)) || (v_reg == fe_t'(1));

    assign in_px = s_tdata[111:0];
    assign in_py = reducem(s_tdata[223:112]);
    assign in_qx = s_tdata[335:224];
    assign in_qy = reducem(s_tdata[447:336]);

    assign done_st = mode_reg ? ST_OUT : ST_STEP;
    assign add_trivial = inf1_reg || inf2_reg || ((x1_reg == x2_reg) &&
                         ((y1_reg != y2_reg) || (y1_reg == '0)));

    always_comb begin
        wr_en   = 1'b0;
        wr_data = alu_res;
        case (state_reg)
            ST_EXEC: wr_en = (cur.op == OP_ADD) || (cur.op == OP_SUB);
            ST_MUL: begin
                wr_en   = mul_last;
                wr_data = mul_step;
            end
            ST_INV: begin
                wr_en   = inv_done;
                wr_data = (u_reg == fe_t'(1)) ? ix1_reg : ix2_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                state_next = s_tuser[0] ? ST_ADD : ST_STEP;
            end
            ST_STEP: begin
                if (!half_reg) begin
                    state_next = (cnt_reg == '0) ? ST_OUT : ST_ADD;
                end else if (k_reg[SCALAR_BITS-1]) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: state_next = add_trivial ? done_st : ST_EXEC;
            ST_EXEC: begin
                unique case (cur.op)
                    OP_MUL:  state_next = ST_MUL;
                    OP_INV:  state_next = ST_INV;
                    OP_END:  state_next = done_st;
                    default: state_next = ST_EXEC;
                endcase
            end
            ST_MUL: if (mul_last) begin
                state_next = ST_EXEC;
            end
            ST_INV: if (inv_done) begin
                state_next = ST_EXEC;
            end
            ST_OUT: if (m_tready) begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        m_tuser  = inf1_reg;
        m_tdata  = inf1_reg ? '1 : {y1_reg, x1_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            case (cur.dst)
                R_X1:    x1_reg <= wr_data;
                R_Y1:    y1_reg <= wr_data;
                R_T0:    t0_reg <= wr_data;
                R_T1:    t1_reg <= wr_data;
                R_T2:    t2_reg <= wr_data;
                R_T3:    t3_reg <= wr_data;
                default: t4_reg <= wr_data;
            endcase
            pc_reg <= pc_reg + PCW'(1);
        end
        case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                mode_reg <= s_tuser[0];
                half_reg <= 1'b0;
                cnt_reg  <= CW'(SCALAR_BITS);
                k_reg    <= s_tdata[448 +: SCALAR_BITS];
                pinf_reg <= (in_px == '1);
                px_reg   <= reducem(in_px);
                py_reg   <= in_py;
                x1_reg   <= reducem(in_px);
                y1_reg   <= in_py;
                x2_reg   <= reducem(in_qx);
                y2_reg   <= in_qy;
                inf2_reg <= (in_qx == '1);
                inf1_reg <= s_tuser[0] ? (in_px == '1) : 1'b1;
            end
            ST_STEP: begin
                if (!half_reg) begin
                    // double: second operand is the accumulator itself
                    x2_reg   <= x1_reg;
                    y2_reg   <= y1_reg;
                    inf2_reg <= inf1_reg;
                    if (cnt_reg != '0) begin
                        half_reg <= 1'b1;
                    end
                end else begin
                    half_reg <= 1'b0;
                    cnt_reg  <= cnt_reg - CW'(1);
                    k_reg    <= k_reg << 1;
                    x2_reg   <= px_reg;
                    y2_reg   <= py_reg;
                    inf2_reg <= pinf_reg;
                end
            end
            ST_ADD: begin
                if (inf1_reg) begin
                    x1_reg   <= x2_reg;
                    y1_reg   <= y2_reg;
                    inf1_reg <= inf2_reg;
                end else if (inf2_reg) begin
                    inf1_reg <= 1'b0;
                end else if (x1_reg == x2_reg) begin
                    if ((y1_reg != y2_reg) || (y1_reg == '0)) begin
                        inf1_reg <= 1'b1;
                    end else begin
                        pc_reg <= DBL_PC;
                    end
                end else begin
                    pc_reg <= CHD_PC;
                end
            end
            ST_EXEC: begin
                if (cur.op == OP_JMP) begin
                    pc_reg <= COM_PC;
                end
                ma_reg   <= opa;
                mb_reg   <= opb;
                macc_reg <= '0;
                mcnt_reg <= MCW'(FE_W);
                u_reg    <= opa;
                v_reg    <= P_MOD;
                ix1_reg  <= fe_t'(1);
                ix2_reg  <= '0;
            end
            ST_MUL: begin
                macc_reg <= mul_step;
                mb_reg   <= mb_reg << 1;
                mcnt_reg <= mcnt_reg - MCW'(1);
            end
            ST_INV: if (!inv_done) begin
                if (!u_reg[0]) begin
                    u_reg   <= u_reg >> 1;
                    ix1_reg <= halfm(ix1_reg);
                end else if (!v_reg[0]) begin
                    v_reg   <= v_reg >> 1;
                    ix2_reg <= halfm(ix2_reg);
                end else if (u_reg >= v_reg) begin
                    u_reg   <= u_reg - v_reg;
                    ix1_reg <= subm(ix1_reg, ix2_reg);
                end else begin
                    v_reg   <= v_reg - u_reg;
                    ix2_reg <= subm(ix2_reg, ix1_reg);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/ecpm_checker.sv =====
// Port-level checks for the point arithmetic core, bound to the top level.
module ecpm_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [223:0] m_tdata,
    input logic [0:0]   m_tuser
);

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped while stalled");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input open while result pending");

    a_inf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == '1))
        else $error("infinity result not all ones");

    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("transfer not followed by work");

endmodule

bind ec_point_add_and_scalar_mult_core ecpm_checker u_ecpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
